### hw/rtl/poai_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// poai_pkg
// Shared types, constants and helpers of the planar odometry arc integrator.
// ----------------------------------------------------------------------------
package poai_pkg;

  localparam int CORDIC_STEPS = 24;
  localparam int CORD_N       = (CORDIC_STEPS > 32) ? 32 : CORDIC_STEPS;
  localparam int DIV_BITS     = 50;

  localparam logic [35:0] INV_GAIN       = 36'd652032874;
  localparam logic [35:0] TURN_PER_RAD   = 36'd683565276;
  localparam logic [31:0] YAW_STEADY_MAX = 32'd6;

  typedef struct packed {
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic               w_neg;
    logic [31:0]        w_mag;
    logic [31:0]        t;
    logic               steady;
  } item_t;

  typedef struct packed {
    logic signed [31:0] pose_x;
    logic signed [31:0] pose_y;
    logic [31:0]        pose_heading;
    logic               yaw_steady;
  } result_t;

  function automatic logic [31:0] atan_entry(input logic [4:0] i);
    logic [31:0] r;
    case (i)
      5'd0:  r = 32'h20000000;
      5'd1:  r = 32'h12E4051E;
      5'd2:  r = 32'h09FB385B;
      5'd3:  r = 32'h051111D4;
      5'd4:  r = 32'h028B0D43;
      5'd5:  r = 32'h0145D7E1;
      5'd6:  r = 32'h00A2F61E;
      5'd7:  r = 32'h00517C55;
      5'd8:  r = 32'h0028BE53;
      5'd9:  r = 32'h00145F2F;
      5'd10: r = 32'h000A2F98;
      5'd11: r = 32'h000517CC;
      5'd12: r = 32'h00028BE6;
      5'd13: r = 32'h000145F3;
      5'd14: r = 32'h0000A2F9;
      5'd15: r = 32'h0000517C;
      5'd16: r = 32'h000028BE;
      5'd17: r = 32'h0000145F;
      5'd18: r = 32'h00000A2F;
      5'd19: r = 32'h00000517;
      5'd20: r = 32'h0000028B;
      5'd21: r = 32'h00000145;
      5'd22: r = 32'h000000A2;
      5'd23: r = 32'h00000051;
      5'd24: r = 32'h00000028;
      5'd25: r = 32'h00000014;
      5'd26: r = 32'h0000000A;
      5'd27: r = 32'h00000005;
      5'd28: r = 32'h00000002;
      5'd29: r = 32'h00000001;
      default: r = 32'h00000000;
    endcase
    return r;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [53:0] v);
    logic signed [31:0] r;
    if ((&v[53:31]) || !(|v[53:31])) begin
      r = v[31:0];
    end else if (v[53]) begin
      r = 32'sh80000000;
    end else begin
      r = 32'sh7FFFFFFF;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

### hw/rtl/poai_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// poai_front
// Accepts input requests, classifies the yaw rate and queues the items.
// ----------------------------------------------------------------------------
module poai_front
  import poai_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  output logic                    full,
  input  wire logic signed [31:0] vel_x,
  input  wire logic signed [31:0] vel_y,
  input  wire logic signed [31:0] yaw_rate,
  input  wire logic [31:0]        elapsed_time,
  output logic                    item_valid,
  input  wire logic               item_take,
  output item_t                   item
);

  item_t       q [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;
  logic        do_push;
  logic        do_pop;
  item_t       new_item;
  logic [31:0] w_mag;

  assign w_mag   = yaw_rate[31] ? 32'(-yaw_rate) : yaw_rate;
  assign full    = (count == 2'd2);
  assign do_push = push && !full;
  assign item_valid = (count != 2'd0);
  assign do_pop  = item_take && item_valid;
  assign item    = q[rd_ptr];

  always_comb begin
    new_item.vel_x  = vel_x;
    new_item.vel_y  = vel_y;
    new_item.w_neg  = yaw_rate[31];
    new_item.w_mag  = w_mag;
    new_item.t      = elapsed_time;
    new_item.steady = (w_mag <= YAW_STEADY_MAX);
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      q[wr_ptr] <= new_item;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= !wr_ptr;
      if (do_pop) rd_ptr <= !rd_ptr;
      count <= count + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule
`default_nettype wire

### hw/rtl/poai_result_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// poai_result_queue
// Two-entry queue of finished poses toward the result port.
// ----------------------------------------------------------------------------
module poai_result_queue
  import poai_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    res_push,
  output logic         res_full,
  input  wire result_t res_in,
  input  wire logic    pop,
  output logic         empty,
  output result_t      res_out
);

  result_t    q [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;

  assign res_full = (count == 2'd2);
  assign empty    = (count == 2'd0);
  assign do_push  = res_push && !res_full;
  assign do_pop   = pop && !empty;
  assign res_out  = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      q[wr_ptr] <= res_in;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= !wr_ptr;
      if (do_pop) rd_ptr <= !rd_ptr;
      count <= count + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule
`default_nettype wire

### hw/rtl/poai_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// poai_back
// Sequencer that integrates one item: shared multiplier, shared CORDIC,
// radix-2 divider for turning items, then pose update and result request.
// ----------------------------------------------------------------------------
module poai_back
  import poai_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               item_valid,
  output logic                    item_take,
  input  wire item_t              item,
  input  wire logic signed [31:0] origin_offset_x,
  input  wire logic signed [31:0] origin_offset_y,
  output logic                    res_push,
  input  wire logic               res_full,
  output result_t                 res
);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_MT0  = 4'd1;
  localparam logic [3:0] ST_MT1  = 4'd2;
  localparam logic [3:0] ST_MT2  = 4'd3;
  localparam logic [3:0] ST_U    = 4'd4;
  localparam logic [3:0] ST_P    = 4'd5;
  localparam logic [3:0] ST_XS   = 4'd6;
  localparam logic [3:0] ST_TH   = 4'd7;
  localparam logic [3:0] ST_CORD = 4'd8;
  localparam logic [3:0] ST_VM   = 4'd9;
  localparam logic [3:0] ST_DIV  = 4'd10;
  localparam logic [3:0] ST_MQ   = 4'd11;
  localparam logic [3:0] ST_FIN  = 4'd12;
  localparam logic [3:0] ST_OUT  = 4'd13;

  localparam logic [1:0] CM_VEC  = 2'd0;
  localparam logic [1:0] CM_ROT1 = 2'd1;
  localparam logic [1:0] CM_ROT2 = 2'd2;

  localparam logic [2:0] MQ_BX = 3'd0;
  localparam logic [2:0] MQ_BY = 3'd1;
  localparam logic [2:0] MQ_T1 = 3'd2;
  localparam logic [2:0] MQ_T2 = 3'd3;
  localparam logic [2:0] MQ_T3 = 3'd4;
  localparam logic [2:0] MQ_T4 = 3'd5;

  localparam logic [1:0] PH_HI  = 2'd0;
  localparam logic [1:0] PH_LO  = 2'd1;
  localparam logic [1:0] PH_SUM = 2'd2;

  logic [3:0]         state;
  logic [5:0]         cnt;
  logic [1:0]         phase;
  logic [2:0]         mq_sel;
  logic [1:0]         cmode;
  logic               cflip;
  item_t              it;
  logic [31:0]        theta;
  logic [31:0]        u_hi;
  logic [31:0]        phi;
  logic [31:0]        alpha;
  logic [31:0]        vbase;
  logic [49:0]        div_reg;
  logic [31:0]        rem;
  logic signed [51:0] r_val;
  logic signed [35:0] st, omc, ch, sh;
  logic signed [51:0] bx, by, t1, t2, t3, t4;
  logic [71:0]        ph;
  logic [71:0]        prod;
  logic signed [35:0] cx, cy;
  logic signed [33:0] cz;
  logic signed [31:0] acc_x, acc_y;
  logic [31:0]        acc_heading;

  logic [35:0]        mul_a, mul_b;
  logic [31:0]        vx_mag, vy_mag;
  logic [39:0]        xs40;
  logic [31:0]        th;
  logic signed [35:0] vx36, vy36;
  logic signed [35:0] xs_sh, ys_sh;
  logic               plus;
  logic signed [33:0] ang;
  logic signed [35:0] c_fin, s_fin;
  logic [31:0]        start_ang;
  logic [31:0]        sa_sum;
  logic [31:0]        a2;
  logic [32:0]        trial;
  logic               trial_ge;
  logic signed [51:0] a_sel;
  logic signed [35:0] b_sel;
  logic [51:0]        ua;
  logic [35:0]        ub;
  logic               mq_neg;
  logic [72:0]        lo_sum;
  logic [65:0]        rq;
  logic signed [51:0] mq_res;
  logic signed [51:0] mt_res;
  logic signed [53:0] sum_x, sum_y;
  logic signed [32:0] px, py;

  assign vx_mag = it.vel_x[31] ? 32'(-it.vel_x) : it.vel_x;
  assign vy_mag = it.vel_y[31] ? 32'(-it.vel_y) : it.vel_y;
  assign vx36   = {{4{it.vel_x[31]}}, it.vel_x};
  assign vy36   = {{4{it.vel_y[31]}}, it.vel_y};
  assign xs40   = prod[39:0] + {8'd0, phi};
  assign th     = xs40[39:8];

  // cordic step
  assign xs_sh = cx >>> cnt[4:0];
  assign ys_sh = cy >>> cnt[4:0];
  assign plus  = (cmode == CM_VEC) ? cy[35] : !cz[33];
  assign ang   = {2'b00, atan_entry(cnt[4:0])};
  assign c_fin = cflip ? -cx : cx;
  assign s_fin = cflip ? -cy : cy;

  always_comb begin
    case (state)
      ST_MT2:  start_ang = acc_heading;
      ST_DIV:  start_ang = theta;
      default: start_ang = acc_heading + alpha;
    endcase
  end
  assign sa_sum = start_ang + 32'h40000000;
  assign a2     = sa_sum[31] ? (start_ang ^ 32'h80000000) : start_ang;

  // divider step
  assign trial    = {rem, div_reg[49]};
  assign trial_ge = (trial >= {1'b0, it.w_mag});

  // truncating products
  always_comb begin
    case (mq_sel)
      MQ_BX, MQ_BY: a_sel = r_val;
      MQ_T1, MQ_T3: a_sel = bx;
      default:      a_sel = by;
    endcase
    case (mq_sel)
      MQ_BX:        b_sel = st;
      MQ_BY:        b_sel = omc;
      MQ_T1, MQ_T4: b_sel = ch;
      default:      b_sel = sh;
    endcase
  end
  assign ua     = a_sel[51] ? 52'(-a_sel) : a_sel;
  assign ub     = b_sel[35] ? 36'(-b_sel) : b_sel;
  assign mq_neg = a_sel[51] ^ b_sel[35];
  assign lo_sum = {43'd0, ph[5:0], 24'd0} + {1'b0, prod};
  assign rq     = ph[71:6] + {23'd0, lo_sum[72:30]};
  assign mq_res = mq_neg ? -$signed(rq[51:0]) : $signed(rq[51:0]);
  assign mt_res = {12'd0, prod[63:24]};

  always_comb begin
    case (state)
      ST_MT0:  begin mul_a = {4'd0, vx_mag};    mul_b = {4'd0, it.t}; end
      ST_MT1:  begin mul_a = {4'd0, vy_mag};    mul_b = {4'd0, it.t}; end
      ST_U:    begin mul_a = {4'd0, it.w_mag};  mul_b = {4'd0, it.t}; end
      ST_P:    begin mul_a = {4'd0, prod[31:0]}; mul_b = TURN_PER_RAD; end
      ST_XS:   begin mul_a = {4'd0, u_hi};      mul_b = TURN_PER_RAD; end
      ST_CORD: begin mul_a = cx;                mul_b = INV_GAIN; end
      ST_MQ:   begin
        mul_a = (phase == PH_HI) ? {8'd0, ua[51:24]} : {12'd0, ua[23:0]};
        mul_b = ub;
      end
      default: begin mul_a = 36'd0; mul_b = 36'd0; end
    endcase
  end

  assign sum_x = {{22{acc_x[31]}}, acc_x} + {{2{t1[51]}}, t1} - {{2{t2[51]}}, t2};
  assign sum_y = {{22{acc_y[31]}}, acc_y} + {{2{t3[51]}}, t3} + {{2{t4[51]}}, t4};
  assign px    = {acc_x[31], acc_x} + {origin_offset_x[31], origin_offset_x};
  assign py    = {acc_y[31], acc_y} + {origin_offset_y[31], origin_offset_y};

  assign item_take = (state == ST_IDLE) && item_valid;
  assign res_push  = (state == ST_OUT) && !res_full;

  always_comb begin
    res.pose_x       = sat32({{21{px[32]}}, px});
    res.pose_y       = sat32({{21{py[32]}}, py});
    res.pose_heading = acc_heading;
    res.yaw_steady   = it.steady;
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    if (rst) begin
      state       <= ST_IDLE;
      cnt         <= 6'd0;
      phase       <= PH_HI;
      mq_sel      <= MQ_BX;
      cmode       <= CM_VEC;
      acc_x       <= 32'sd0;
      acc_y       <= 32'sd0;
      acc_heading <= 32'd0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (item_valid) begin
            it    <= item;
            theta <= 32'd0;
            state <= item.steady ? ST_MT0 : ST_U;
          end
        end
        ST_MT0: state <= ST_MT1;
        ST_MT1: begin
          bx    <= it.vel_x[31] ? -mt_res : mt_res;
          state <= ST_MT2;
        end
        ST_MT2: begin
          by    <= it.vel_y[31] ? -mt_res : mt_res;
          cx    <= INV_GAIN;
          cy    <= 36'sd0;
          cz    <= {{2{a2[31]}}, a2};
          cflip <= sa_sum[31];
          cmode <= CM_ROT2;
          cnt   <= 6'd0;
          state <= ST_CORD;
        end
        ST_U: state <= ST_P;
        ST_P: begin
          u_hi  <= prod[63:32];
          state <= ST_XS;
        end
        ST_XS: begin
          phi   <= prod[63:32];
          state <= ST_TH;
        end
        ST_TH: begin
          theta <= it.w_neg ? -th : th;
          cx    <= vx36[35] ? -vx36 : vx36;
          cy    <= vx36[35] ? -vy36 : vy36;
          vbase <= vx36[35] ? 32'h80000000 : 32'd0;
          cz    <= 34'sd0;
          cmode <= CM_VEC;
          cnt   <= 6'd0;
          state <= ST_CORD;
        end
        ST_CORD: begin
          if (cnt == 6'(CORD_N)) begin
            cnt <= 6'd0;
            case (cmode)
              CM_VEC: begin
                alpha <= vbase + cz[31:0];
                state <= ST_VM;
              end
              CM_ROT1: begin
                st    <= s_fin;
                omc   <= 36'sd1073741824 - c_fin;
                cx    <= INV_GAIN;
                cy    <= 36'sd0;
                cz    <= {{2{a2[31]}}, a2};
                cflip <= sa_sum[31];
                cmode <= CM_ROT2;
              end
              default: begin
                ch     <= c_fin;
                sh     <= s_fin;
                mq_sel <= it.steady ? MQ_T1 : MQ_BX;
                phase  <= PH_HI;
                state  <= ST_MQ;
              end
            endcase
          end else begin
            if (plus) begin
              cx <= cx - ys_sh;
              cy <= cy + xs_sh;
              cz <= cz - ang;
            end else begin
              cx <= cx + ys_sh;
              cy <= cy - xs_sh;
              cz <= cz + ang;
            end
            cnt <= cnt + 6'd1;
          end
        end
        ST_VM: begin
          div_reg <= {prod[63:30], 16'd0};
          rem     <= 32'd0;
          cnt     <= 6'd0;
          state   <= ST_DIV;
        end
        ST_DIV: begin
          if (cnt == 6'(DIV_BITS)) begin
            r_val <= it.w_neg ? -$signed({2'b00, div_reg}) : $signed({2'b00, div_reg});
            cx    <= INV_GAIN;
            cy    <= 36'sd0;
            cz    <= {{2{a2[31]}}, a2};
            cflip <= sa_sum[31];
            cmode <= CM_ROT1;
            cnt   <= 6'd0;
            state <= ST_CORD;
          end else begin
            rem     <= trial_ge ? 32'(trial - {1'b0, it.w_mag}) : trial[31:0];
            div_reg <= {div_reg[48:0], trial_ge};
            cnt     <= cnt + 6'd1;
          end
        end
        ST_MQ: begin
          case (phase)
            PH_HI: phase <= PH_LO;
            PH_LO: begin
              ph    <= prod;
              phase <= PH_SUM;
            end
            default: begin
              case (mq_sel)
                MQ_BX:   bx <= mq_res;
                MQ_BY:   by <= mq_res;
                MQ_T1:   t1 <= mq_res;
                MQ_T2:   t2 <= mq_res;
                MQ_T3:   t3 <= mq_res;
                default: t4 <= mq_res;
              endcase
              phase <= PH_HI;
              if (mq_sel == MQ_T4) begin
                state <= ST_FIN;
              end else begin
                mq_sel <= mq_sel + 3'd1;
              end
            end
          endcase
        end
        ST_FIN: begin
          acc_x       <= sat32(sum_x);
          acc_y       <= sat32(sum_y);
          acc_heading <= acc_heading + theta;
          state       <= ST_OUT;
        end
        ST_OUT: begin
          if (!res_full) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_out_done: assert property (@(posedge clk) disable iff (rst)
    (state == ST_OUT && !res_full) |=> (state == ST_IDLE))
    else $error("result request did not end the item");

  a_take_start: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE && item_valid) |=> (state == ST_MT0 || state == ST_U))
    else $error("taken item did not start work");

  a_div_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV) |-> (cnt <= 6'(DIV_BITS)))
    else $error("divider overran");

  a_cord_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CORD) |-> (cnt <= 6'(CORD_N)))
    else $error("cordic overran");

endmodule
`default_nettype wire

### hw/rtl/planar_odometry_arc_integrator_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// planar_odometry_arc_integrator_core
// Dead-reckoning pose integrator over straight steps and circular arcs.
// ----------------------------------------------------------------------------
// Each input request is taken into a two-entry queue, and one sequencer
// integrates one item at a time with a shared multiplier, a shared CORDIC
// of CORDIC_STEPS (N) iterations and a one-bit-per-cycle divider. An item
// whose yaw rate is steady takes one CORDIC pass; a turning item takes
// three CORDIC passes and a 50-bit division. Results wait in a two-entry
// queue.
module planar_odometry_arc_integrator_core
  import poai_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_write,
  input  wire logic               cfg_index,
  input  wire logic [31:0]        cfg_data,
  input  wire logic               push,
  output logic                    full,
  input  wire logic signed [31:0] vel_x,
  input  wire logic signed [31:0] vel_y,
  input  wire logic signed [31:0] yaw_rate,
  input  wire logic [31:0]        elapsed_time,
  output logic                    empty,
  input  wire logic               pop,
  output logic signed [31:0]      pose_x,
  output logic signed [31:0]      pose_y,
  output logic [31:0]             pose_heading,
  output logic                    yaw_steady
);

  localparam logic REG_OFFSET_X = 1'b0;
  localparam logic REG_OFFSET_Y = 1'b1;

  logic signed [31:0] origin_offset_x;
  logic signed [31:0] origin_offset_y;
  logic               item_valid;
  logic               item_take;
  item_t              item;
  logic               res_push;
  logic               res_full;
  result_t            res_in;
  result_t            res_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      origin_offset_x <= 32'sd0;
      origin_offset_y <= 32'sd0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_OFFSET_X: origin_offset_x <= cfg_data;
        REG_OFFSET_Y: origin_offset_y <= cfg_data;
        default: ;
      endcase
    end
  end

  poai_front u_front (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .vel_x        (vel_x),
    .vel_y        (vel_y),
    .yaw_rate     (yaw_rate),
    .elapsed_time (elapsed_time),
    .item_valid   (item_valid),
    .item_take    (item_take),
    .item         (item)
  );

  poai_back u_back (
    .clk             (clk),
    .rst             (rst),
    .item_valid      (item_valid),
    .item_take       (item_take),
    .item            (item),
    .origin_offset_x (origin_offset_x),
    .origin_offset_y (origin_offset_y),
    .res_push        (res_push),
    .res_full        (res_full),
    .res             (res_in)
  );

  poai_result_queue u_res_q (
    .clk      (clk),
    .rst      (rst),
    .res_push (res_push),
    .res_full (res_full),
    .res_in   (res_in),
    .pop      (pop),
    .empty    (empty),
    .res_out  (res_out)
  );

  assign pose_x       = res_out.pose_x;
  assign pose_y       = res_out.pose_y;
  assign pose_heading = res_out.pose_heading;
  assign yaw_steady   = res_out.yaw_steady;

endmodule
`default_nettype wire

### verif/tb_planar_odometry_arc_integrator_core.sv
// ----------------------------------------------------------------------------
// tb_planar_odometry_arc_integrator_core
// Self-checking bench for the planar odometry arc integrator. A short table of
// directed requests (reset pose, steady-yaw edges, extreme velocities, times
// and yaw rates, saturation, heading wrap) is followed by random requests over
// several origin offsets and idle patterns. Every pose is checked against a
// bit-exact dead-reckoning model in the bench, or the pose set in its row.
// ----------------------------------------------------------------------------
module tb_planar_odometry_arc_integrator_core;
  import poai_pkg::*;

  localparam logic CFG_OFFSET_X = 1'b0;
  localparam logic CFG_OFFSET_Y = 1'b1;
  localparam longint GAIN_FIX = 652032874;
  localparam longint RAD_TO_TURN = 683565276;
  localparam longint STEADY_LIMIT = 6;
  localparam longint POS_MAX = 64'sd2147483647;
  localparam longint POS_MIN = -64'sd2147483648;
  localparam int SETTLE_CYCLES = 400;
  localparam int CYCLE_LIMIT = 1500000;
  localparam int RANDOM_PER_PHASE = 360;

  localparam logic [31:0] ARC_TAB [0:31] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
    32'h0000517C, 32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
    32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051, 32'h00000028,
    32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000002, 32'h00000001,
    32'h00000000, 32'h00000000
  };

  typedef struct {
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic signed [31:0] w;
    logic [31:0]        t;
    bit                 typed;
    result_t            res;
  } stim_row_t;

  logic               clk;
  logic               rst;
  logic               cfg_write;
  logic               cfg_index;
  logic [31:0]        cfg_data;
  logic               push;
  logic               full;
  logic signed [31:0] vel_x;
  logic signed [31:0] vel_y;
  logic signed [31:0] yaw_rate;
  logic [31:0]        elapsed_time;
  logic               empty;
  logic               pop;
  logic signed [31:0] pose_x;
  logic signed [31:0] pose_y;
  logic [31:0]        pose_heading;
  logic               yaw_steady;

  logic    row_typed;
  result_t row_res;

  longint      pos_x, pos_y, off_x, off_y;
  logic [31:0] heading;

  result_t pending_poses[$];
  int      mismatches, poses_checked, requests_sent, steady_seen, cycles;
  int      send_idle_pct, recv_idle_pct;

  stim_row_t directed[$];

  planar_odometry_arc_integrator_core uut (
    .clk(clk), .rst(rst), .cfg_write(cfg_write), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .push(push), .full(full), .vel_x(vel_x),
    .vel_y(vel_y), .yaw_rate(yaw_rate), .elapsed_time(elapsed_time),
    .empty(empty), .pop(pop), .pose_x(pose_x), .pose_y(pose_y),
    .pose_heading(pose_heading), .yaw_steady(yaw_steady)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic longint clamp32(input longint v);
    if (v > POS_MAX) return POS_MAX;
    if (v < POS_MIN) return POS_MIN;
    return v;
  endfunction

  // a * b / 2^30, truncated toward zero
  function automatic longint mul_q30(input longint a, input longint b);
    longint unsigned ua, ub, hi, lo, ph, pl, r;
    ua = (a < 0) ? longint'(-a) : a;
    ub = (b < 0) ? longint'(-b) : b;
    hi = ua >> 24;
    lo = ua & 64'hFFFFFF;
    ph = hi * ub;
    pl = lo * ub;
    r = (ph >> 6) + ((((ph & 64'd63) << 24) + pl) >> 30);
    return ((a < 0) != (b < 0)) ? -longint'(r) : longint'(r);
  endfunction

  function automatic longint scale_time(input longint v, input longint unsigned t);
    longint unsigned m;
    m = (v < 0) ? longint'(-v) : v;
    m = (m * t) >> 24;
    return (v < 0) ? -longint'(m) : longint'(m);
  endfunction

  function automatic void rotate_unit(input logic [31:0] ang, output longint c,
                                      output longint s);
    logic [31:0] a, q;
    logic        flip;
    longint      x, y, z, nx;
    a = ang;
    q = a + 32'h40000000;
    flip = q[31];
    if (flip) a = a - 32'h80000000;
    x = GAIN_FIX;
    y = 0;
    z = longint'($signed(a));
    for (int i = 0; i < CORD_N; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y = y + (x >>> i);
        z = z - longint'(ARC_TAB[i]);
      end else begin
        nx = x + (y >>> i);
        y = y - (x >>> i);
        z = z + longint'(ARC_TAB[i]);
      end
      x = nx;
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    c = x;
    s = y;
  endfunction

  function automatic void polar_of(input longint xi, input longint yi,
                                   output longint unsigned mag, output logic [31:0] ang);
    logic [31:0] base;
    longint      x, y, z, nx;
    x = xi;
    y = yi;
    z = 0;
    base = 32'h0;
    if (x < 0) begin
      x = -x;
      y = -y;
      base = 32'h80000000;
    end
    for (int i = 0; i < CORD_N; i++) begin
      if (y >= 0) begin
        nx = x + (y >>> i);
        y = y - (x >>> i);
        z = z + longint'(ARC_TAB[i]);
      end else begin
        nx = x - (y >>> i);
        y = y + (x >>> i);
        z = z - longint'(ARC_TAB[i]);
      end
      x = nx;
    end
    mag = (longint'(x) * GAIN_FIX) >> 30;
    ang = base + z[31:0];
  endfunction

  // advance the kept pose by one odometry update and return the reported pose
  function automatic result_t integrate_step(input longint vx, input longint vy,
                                             input longint w, input longint unsigned t);
    result_t         r;
    longint unsigned uw, u, uh, ul, p, xs, vmag, rmag;
    longint          bx, by, ch, sh, ct, st, rad, dx, dy;
    logic [31:0]     theta, alpha, rot;
    logic            steady;
    uw = (w < 0) ? longint'(-w) : w;
    steady = (uw <= STEADY_LIMIT);
    theta = 32'h0;
    rot = heading;
    if (steady) begin
      bx = scale_time(vx, t);
      by = scale_time(vy, t);
    end else begin
      u = uw * t;
      uh = u >> 32;
      ul = u & 64'hFFFFFFFF;
      p = ul * RAD_TO_TURN;
      xs = uh * RAD_TO_TURN + (p >> 32);
      theta = xs[39:8];
      if (w < 0) theta = -theta;
      polar_of(vx, vy, vmag, alpha);
      rmag = (vmag << 16) / uw;
      rad = (w < 0) ? -longint'(rmag) : longint'(rmag);
      rotate_unit(theta, ct, st);
      bx = mul_q30(rad, st);
      by = mul_q30(rad, (64'sd1 << 30) - ct);
      rot = heading + alpha;
    end
    rotate_unit(rot, ch, sh);
    dx = mul_q30(bx, ch) - mul_q30(by, sh);
    dy = mul_q30(bx, sh) + mul_q30(by, ch);
    pos_x = clamp32(pos_x + dx);
    pos_y = clamp32(pos_y + dy);
    heading = heading + theta;
    r.pose_x = clamp32(pos_x + off_x);
    r.pose_y = clamp32(pos_y + off_y);
    r.pose_heading = heading;
    r.yaw_steady = steady;
    return r;
  endfunction

  function automatic stim_row_t mk_row(input logic [31:0] vx, input logic [31:0] vy,
                                       input logic [31:0] w, input logic [31:0] t,
                                       input bit typed, input logic [31:0] ex,
                                       input logic [31:0] ey, input logic [31:0] eh,
                                       input logic es);
    stim_row_t r;
    r.vx = vx;
    r.vy = vy;
    r.w = w;
    r.t = t;
    r.typed = typed;
    r.res.pose_x = ex;
    r.res.pose_y = ey;
    r.res.pose_heading = eh;
    r.res.yaw_steady = es;
    return r;
  endfunction

  function automatic logic [31:0] rand_vel();
    case ($urandom_range(9))
      0, 1, 2: return $urandom;
      3: return $urandom_range(1) ? 32'h7FFFFFFF : 32'h80000000;
      default: return $urandom_range(32'h200000) - 32'h100000;
    endcase
  endfunction

  function automatic logic [31:0] rand_yaw();
    case ($urandom_range(9))
      0, 1: return $urandom_range(12) - 6;
      2: return $urandom;
      3: return $urandom_range(1) ? 32'h7FFFFFFF : 32'h80000000;
      default: return $urandom_range(32'h80000) - 32'h40000;
    endcase
  endfunction

  function automatic logic [31:0] rand_time();
    case ($urandom_range(9))
      0: return $urandom;
      1: return $urandom_range(1) ? 32'hFFFFFFFF : 32'h0;
      default: return $urandom_range(32'h1000000);
    endcase
  endfunction

  // checker: predictions at accepted requests, compare at accepted results
  always @(posedge clk) begin
    result_t want, pred;
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("tb_planar_odometry_arc_integrator_core NOT OK");
      $finish;
    end
    if (!rst) begin
      if (cfg_write) begin
        if (cfg_index == CFG_OFFSET_X) off_x = longint'($signed(cfg_data));
        else off_y = longint'($signed(cfg_data));
      end
      if (push && !full) begin
        pred = integrate_step(longint'(vel_x), longint'(vel_y), longint'(yaw_rate),
                              longint'({32'h0, elapsed_time}));
        pending_poses.push_back(row_typed ? row_res : pred);
      end
      if (pop && !empty) begin
        if (pending_poses.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result x=%0d y=%0d", pose_x, pose_y);
        end else begin
          want = pending_poses.pop_front();
          poses_checked++;
          if (yaw_steady) steady_seen++;
          if (pose_x !== want.pose_x || pose_y !== want.pose_y ||
              pose_heading !== want.pose_heading || yaw_steady !== want.yaw_steady) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch #%0d: exp x=%0d y=%0d h=%h s=%b got x=%0d y=%0d h=%h s=%b",
                       poses_checked, want.pose_x, want.pose_y, want.pose_heading,
                       want.yaw_steady, pose_x, pose_y, pose_heading, yaw_steady);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    pop <= ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic send(input stim_row_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    vel_x <= r.vx;
    vel_y <= r.vy;
    yaw_rate <= r.w;
    elapsed_time <= r.t;
    row_typed <= r.typed;
    row_res <= r.res;
    do @(posedge clk); while (full);
    requests_sent++;
  endtask

  task automatic drain();
    push <= 1'b0;
    @(posedge clk);
    while (pending_poses.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_offsets(input logic [31:0] ox, input logic [31:0] oy);
    cfg_write <= 1'b1;
    cfg_index <= CFG_OFFSET_X;
    cfg_data <= ox;
    @(posedge clk);
    cfg_index <= CFG_OFFSET_Y;
    cfg_data <= oy;
    @(posedge clk);
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  task automatic random_phase(input int n);
    stim_row_t r;
    for (int i = 0; i < n; i++) begin
      r = mk_row(rand_vel(), rand_vel(), rand_yaw(), rand_time(), 0, 0, 0, 0, 0);
      send(r);
    end
  endtask

  initial begin
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = CFG_OFFSET_X;
    cfg_data = '0;
    push = 1'b0;
    pop = 1'b0;
    vel_x = '0;
    vel_y = '0;
    yaw_rate = '0;
    elapsed_time = '0;
    row_typed = 1'b0;
    row_res = '0;
    pos_x = 0;
    pos_y = 0;
    off_x = 0;
    off_y = 0;
    heading = '0;
    mismatches = 0;
    poses_checked = 0;
    requests_sent = 0;
    steady_seen = 0;
    cycles = 0;
    send_idle_pct = 11;
    recv_idle_pct = 63;

    // reset pose, steady-yaw edges with no motion
    directed.push_back(mk_row(0, 0, 0, 0, 1, 0, 0, 0, 1));
    directed.push_back(mk_row(0, 0, 6, 32'hFFFFFFFF, 1, 0, 0, 0, 1));
    directed.push_back(mk_row(0, 0, -6, 32'hFFFFFFFF, 1, 0, 0, 0, 1));
    directed.push_back(mk_row(32'h7FFFFFFF, 32'h80000000, 0, 0, 1, 0, 0, 0, 1));
    // first turning rates, zero velocity still turns
    directed.push_back(mk_row(0, 0, 7, 32'hFFFFFFFF, 0, 0, 0, 0, 0));
    directed.push_back(mk_row(0, 0, -7, 32'h01000000, 0, 0, 0, 0, 0));
    directed.push_back(mk_row(32'h00010000, 0, 0, 32'h01000000, 0, 0, 0, 0, 0));
    directed.push_back(mk_row(0, 32'h00010000, 32'h00010000, 32'h01000000, 0, 0, 0, 0, 0));
    // position saturation both ways
    directed.push_back(mk_row(32'h7FFFFFFF, 32'h7FFFFFFF, 0, 32'hFFFFFFFF, 0, 0, 0, 0, 0));
    directed.push_back(mk_row(32'h80000000, 32'h80000000, 0, 32'hFFFFFFFF, 0, 0, 0, 0, 0));
    directed.push_back(mk_row(32'h80000000, 32'h80000000, 0, 32'hFFFFFFFF, 0, 0, 0, 0, 0));
    directed.push_back(mk_row(32'h7FFFFFFF, 0, 0, 32'hFFFFFFFF, 0, 0, 0, 0, 0));
    // extreme yaw rates and heading wrap
    directed.push_back(mk_row(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'hFFFFFFFF,
                              0, 0, 0, 0, 0));
    directed.push_back(mk_row(32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'hFFFFFFFF,
                              0, 0, 0, 0, 0));
    directed.push_back(mk_row(32'h80000000, 0, 32'h80000000, 1, 0, 0, 0, 0, 0));
    directed.push_back(mk_row(1, -1, 32'h7FFFFFFF, 0, 0, 0, 0, 0, 0));
    directed.push_back(mk_row(32'h00030000, 32'hFFFE0000, 32'h0001921F, 32'h04000000,
                              0, 0, 0, 0, 0));
    directed.push_back(mk_row(32'hFFFF0000, 32'h00008000, 32'hFFFF0000, 32'h03000000,
                              0, 0, 0, 0, 0));
    directed.push_back(mk_row(32'h00001000, 32'h00001000, 32'h00064000, 32'h00800000,
                              0, 0, 0, 0, 0));
    directed.push_back(mk_row(32'h55555555, 32'hAAAAAAAA, 32'h55555555, 32'hAAAAAAAA,
                              0, 0, 0, 0, 0));
    directed.push_back(mk_row(32'hAAAAAAAA, 32'h55555555, 32'hAAAAAAAA, 32'h55555555,
                              0, 0, 0, 0, 0));

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed[i]) send(directed[i]);
    drain();

    write_offsets(32'h7FFFFFFF, 32'h80000000);
    random_phase(RANDOM_PER_PHASE);
    drain();

    send_idle_pct = 63;
    recv_idle_pct = 11;
    write_offsets(32'h80000000, 32'h7FFFFFFF);
    random_phase(RANDOM_PER_PHASE);
    drain();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_offsets($urandom, $urandom);
    random_phase(RANDOM_PER_PHASE);
    drain();

    write_offsets($urandom_range(32'h200000) - 32'h100000, 32'h0);
    random_phase(RANDOM_PER_PHASE);
    drain();

    $display("%0d odometry requests sent, %0d poses checked (%0d steady yaw)",
             requests_sent, poses_checked, steady_seen);
    $display("four offset settings incl. both extremes, %0d mismatches", mismatches);
    if (mismatches == 0) begin
      $display("tb_planar_odometry_arc_integrator_core OK");
    end else begin
      $display("tb_planar_odometry_arc_integrator_core NOT OK");
    end
    $finish;
  end

endmodule

### files.f
hw/rtl/poai_pkg.sv
hw/rtl/poai_front.sv
hw/rtl/poai_result_queue.sv
hw/rtl/poai_back.sv
hw/rtl/planar_odometry_arc_integrator_core.sv
verif/tb_planar_odometry_arc_integrator_core.sv
